// File: hw/rtl/lpht_pkg.sv
// Shared types, constants and helper functions for the linear-probing hash table.
// Depends on nothing; lpht_front, lpht_queue, lpht_back and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  // Table capacity and derived widths.
  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SIZE_W = SLOT_W + 1;

  // Field widths.
  localparam int CFG_W  = 11;
  localparam int ACT_W  = 2;
  localparam int KEY_W  = 63;
  localparam int DATA_W = 64;
  localparam int STAT_W = 2;
  localparam int MARK_W = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Remainder unit: key bits consumed per cycle and cycle count.
  localparam int DIV_BITS = 4;
  localparam int DIV_CYC  = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W    = DIV_CYC * DIV_BITS;
  localparam int DCNT_W   = $clog2(DIV_CYC);

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Slot marks.
  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] value;
  } result_t;

  // A request once its home slot is known.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic [SLOT_W-1:0] home;
  } work_t;

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE,
    B_DONE
  } back_state_t;

  // Size in use: zero behaves as one, anything above capacity as capacity.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] ts);
    logic [SIZE_W-1:0] s;
    if (ts == '0) begin
      s = SIZE_W'(1);
    end else if (32'(ts) > SLOTS) begin
      s = SIZE_W'(SLOTS);
    end else begin
      s = SIZE_W'(ts);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/lpht_front.sv
// Front end: accepts requests and works out the home slot, key modulo size.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpht_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lpht_pkg::req_t               in_req,
  input  wire logic                         hold,
  input  wire logic [lpht_pkg::SIZE_W-1:0]  size,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output lpht_pkg::work_t                   push_work
);

  import lpht_pkg::*;

  front_state_t      state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [PAD_W-1:0]  sh_r, sh_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [SIZE_W-1:0] step_rem;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    sh_nxt     = sh_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    step_rem   = rem_r;
    in_ready   = (state_r == F_IDLE) && !hold;
    push_valid = (state_r == F_PUSH);
    push_work  = '{action: req_r.action, key: req_r.key, data: req_r.data,
                   home: rem_r[SLOT_W-1:0]};

    unique case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt   = in_req;
          sh_nxt    = PAD_W'(in_req.key);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        // Restoring remainder, several key bits per cycle, most significant first.
        for (int i = 0; i < DIV_BITS; i++) begin
          step_rem = {step_rem[SIZE_W-2:0], sh_r[PAD_W-1-i]};
          if (step_rem >= size) begin
            step_rem = step_rem - size;
          end
        end
        rem_nxt = step_rem;
        sh_nxt  = sh_r << DIV_BITS;
        cnt_nxt = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(DIV_CYC - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/lpht_queue.sv
// Short request queue between the front end and the probe engine.
// Depends on lpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpht_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire lpht_pkg::work_t push_work,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output lpht_pkg::work_t      pop_work
);

  import lpht_pkg::*;

  work_t             q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_work   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_work;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lpht_back.sv
// Probe engine: walks the slot memory, updates it and holds the result register.
// Depends on lpht_pkg and lpht_ram.
`timescale 1ns / 1ps
`default_nettype none

module lpht_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        clr_start,
  input  wire logic [lpht_pkg::SIZE_W-1:0] size,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire lpht_pkg::work_t             pop_work,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output lpht_pkg::result_t                out_res,
  output lpht_pkg::back_stat_t             stat
);

  import lpht_pkg::*;

  back_state_t          state_r, state_nxt;
  work_t                cur_r, cur_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [SIZE_W-1:0]    n_r, n_nxt;
  logic [SLOT_W-1:0]    clr_r, clr_nxt;
  result_t              res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  result_t              out_res_r;
  logic                 out_load;

  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_addr;
  slot_t                wr_slot;
  logic [SLOT_W-1:0]    rd_addr;
  logic [SLOT_BITS-1:0] rd_word;
  slot_t                ent;
  logic [SLOT_W-1:0]    idx_step;
  logic                 last_probe;

  lpht_ram #(
    .WIDTH(SLOT_BITS),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(SLOT_BITS'(wr_slot)),
    .rd_addr(rd_addr),
    .rd_data(rd_word)
  );

  assign ent        = slot_t'(rd_word);
  assign idx_step   = ((SIZE_W'(idx_r) + SIZE_W'(1)) == size) ? '0 : idx_r + SLOT_W'(1);
  assign last_probe = ((n_r + SIZE_W'(1)) == size);
  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;
  assign stat       = '{clearing: (state_r == B_CLEAR)};

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    pop_ready = 1'b0;
    out_load  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_slot   = ent;
    rd_addr   = idx_r;

    unique case (state_r)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_slot = '{mark: MARK_EMPTY, key: '0, value: '0};
        clr_nxt = clr_r + SLOT_W'(1);
        if (clr_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        pop_ready = 1'b1;
        rd_addr   = pop_work.home;
        if (pop_valid) begin
          cur_nxt = pop_work;
          idx_nxt = pop_work.home;
          n_nxt   = '0;
          if (pop_work.action == ACT_SEARCH || pop_work.action == ACT_INSERT ||
              pop_work.action == ACT_DELETE) begin
            state_nxt = B_PROBE;
          end else begin
            res_nxt   = '{status: ST_MISS, value: '0};
            state_nxt = B_DONE;
          end
        end
      end
      B_PROBE: begin
        // The slot at idx_r is on the read port this cycle.
        if (cur_r.action == ACT_INSERT) begin
          if (ent.mark != MARK_USED) begin
            wr_en     = 1'b1;
            wr_slot   = '{mark: MARK_USED, key: cur_r.key, value: cur_r.data};
            res_nxt   = '{status: ST_OK, value: '0};
            state_nxt = B_DONE;
          end else if (last_probe) begin
            res_nxt   = '{status: ST_FULL, value: '0};
            state_nxt = B_DONE;
          end else begin
            idx_nxt = idx_step;
            n_nxt   = n_r + SIZE_W'(1);
            rd_addr = idx_step;
          end
        end else begin
          if (ent.mark == MARK_EMPTY) begin
            res_nxt   = '{status: ST_MISS, value: '0};
            state_nxt = B_DONE;
          end else if (ent.mark == MARK_USED && ent.key == cur_r.key) begin
            res_nxt = '{status: ST_OK, value: ent.value};
            if (cur_r.action == ACT_DELETE) begin
              wr_en   = 1'b1;
              wr_slot = '{mark: MARK_TOMB, key: ent.key, value: ent.value};
            end
            state_nxt = B_DONE;
          end else if (last_probe) begin
            res_nxt   = '{status: ST_MISS, value: '0};
            state_nxt = B_DONE;
          end else begin
            idx_nxt = idx_step;
            n_nxt   = n_r + SIZE_W'(1);
            rd_addr = idx_step;
          end
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // A size write empties the whole table.
    if (clr_start) begin
      state_nxt = B_CLEAR;
      clr_nxt   = '0;
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/linear_probe_hash_table.sv
// Top level of the open-addressing hash table with linear probing.
// Depends on lpht_pkg, lpht_front, lpht_queue, lpht_back (and lpht_ram below it).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   in_req  (action, key, data)
// out_      output     out_valid / out_ready out_res (status, value)
// cfg_      input      cfg_we, no wait       cfg_wdata (table_size)
//
// The front end takes one request, then forms key modulo size in a four-bit-per-cycle
// remainder unit, hands it to the queue once the queue has room and only then is ready
// again, so it works on one request at a time; that unit sets the request rate whenever
// probes are short. The probe engine reads one slot per cycle from the slot memory,
// which has one read and one write port, and a request visits at most as many slots as
// the table size before its result is handed over.
// After reset, and after every write of table_size, a clearing pass marks all 1024 slots
// empty; in_ready stays low throughout. Either side may stall freely: the queue and the
// result register decouple the front end, the engine and the consumer.

module linear_probe_hash_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire lpht_pkg::req_t             in_req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output lpht_pkg::result_t               out_res,
  input  wire logic                       cfg_we,
  input  wire logic [lpht_pkg::CFG_W-1:0] cfg_wdata
);

  import lpht_pkg::*;

  // Configured size as written; the clamped size in use is derived from it.
  logic [CFG_W-1:0]  table_size_r, table_size_nxt;
  logic [SIZE_W-1:0] size;

  logic       push_valid, push_ready;
  work_t      push_work;
  logic       pop_valid, pop_ready;
  work_t      pop_work;
  back_stat_t back_stat;

  assign table_size_nxt = cfg_we ? cfg_wdata : table_size_r;
  assign size           = eff_size(table_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= CFG_RESET;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  // Requests are held off while the slot memory is being cleared.
  lpht_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .hold      (back_stat.clearing),
    .size      (size),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_work (push_work)
  );

  lpht_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_work (push_work),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_work  (pop_work)
  );

  // The engine owns the slot memory and starts a clearing pass on every size write.
  lpht_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_start(cfg_we),
    .size     (size),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_work (pop_work),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res),
    .stat     (back_stat)
  );

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for linear_probe_hash_table: drives search, insert and delete
// requests, predicts every result from its own copy of the slot table and compares them.
// Depends on lpht_pkg for the request and result types and on the RTL under hw/rtl.
`timescale 1ns / 1ps

module tb;
  import lpht_pkg::*;

  // The block accepts action code 3 but treats it as a no-op that answers "not found".
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;
  localparam logic [DATA_W-1:0] DATA_TOP = '1;
  localparam int RANDOM_ITEMS = 1880;
  // Long receiver hold-off; far longer than the block can buffer, so in_ready must drop.
  localparam int LONG_HOLD = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  result_t out_res;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  linear_probe_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the slot table. Keys and data are only ever read from used slots, so
  // entries that were never written are never consulted.
  logic [MARK_W-1:0] tbl_mark [SLOTS];
  logic [KEY_W-1:0]  tbl_key  [SLOTS];
  logic [DATA_W-1:0] tbl_data [SLOTS];
  int tbl_size;

  req_t    pending_reqs[$];
  result_t expected_results[$];
  int      mismatches = 0;

  // Sender and receiver pacing state.
  logic in_taken = 1'b0;
  logic tx_live = 1'b0;
  int   tx_gap = 0;
  int   tx_quiet = 0;
  logic rx_taken = 1'b0;
  logic rx_hold_req = 1'b0;
  int   rx_hold = 0;
  int   rx_wait = 0;
  int   rx_quiet = 0;
  result_t rx_want;

  // Empties every slot and sets the size in use. A size of zero behaves as one, and
  // anything above the capacity behaves as the capacity.
  function automatic void reset_model(input logic [CFG_W-1:0] size_cfg);
    if (size_cfg == '0) begin
      tbl_size = 1;
    end else if (int'(size_cfg) > SLOTS) begin
      tbl_size = SLOTS;
    end else begin
      tbl_size = int'(size_cfg);
    end
    for (int i = 0; i < SLOTS; i++) begin
      tbl_mark[i] = MARK_EMPTY;
    end
  endfunction

  // Applies one request to the shadow table and returns the result it must produce.
  // Probing starts at the home slot, wraps at the size in use and stops after twice the
  // size. Search and delete stop early at an empty slot but walk over tombstones; insert
  // takes the first slot that is not in use, tombstones included.
  function automatic result_t table_access(input req_t r);
    result_t res;
    int idx;
    int hit;
    res.status = ST_MISS;
    res.value = '0;
    idx = int'({1'b0, r.key} % 64'(tbl_size));
    hit = -1;
    case (r.action)
      ACT_INSERT: begin
        res.status = ST_FULL;
        for (int n = 0; n < 2 * tbl_size; n++) begin
          if (tbl_mark[idx] != MARK_USED) begin
            tbl_mark[idx] = MARK_USED;
            tbl_key[idx] = r.key;
            tbl_data[idx] = r.data;
            res.status = ST_OK;
            break;
          end
          idx = (idx + 1 == tbl_size) ? 0 : idx + 1;
        end
      end
      ACT_SEARCH, ACT_DELETE: begin
        for (int n = 0; n < 2 * tbl_size; n++) begin
          if (tbl_mark[idx] == MARK_EMPTY) begin
            break;
          end
          if (tbl_mark[idx] == MARK_USED && tbl_key[idx] == r.key) begin
            hit = idx;
            break;
          end
          idx = (idx + 1 == tbl_size) ? 0 : idx + 1;
        end
        if (hit >= 0) begin
          res.status = ST_OK;
          res.value = tbl_data[hit];
          if (r.action == ACT_DELETE) begin
            tbl_mark[hit] = MARK_TOMB;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Idle cycles before the next request or result. Now and then a run of requests goes
  // through with no idling at all, so back-to-back traffic is covered as well.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  task automatic queue_req(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                           input logic [DATA_W-1:0] data);
    req_t r;
    r.action = act;
    r.key = key;
    r.data = data;
    pending_reqs.push_back(r);
  endtask

  // Returns at a falling edge once no request is waiting or on offer and every expected
  // result has been taken. The sender's own offer flag is used rather than in_valid, as
  // in_valid is only updated after the falling-edge processes have run.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || tx_live || expected_results.size() != 0);
  endtask

  // The block is idle when this is called; the write also empties the table, and the
  // block then runs its clearing pass with in_ready low.
  task automatic write_table_size(input logic [CFG_W-1:0] size_cfg);
    cfg_wdata = size_cfg;
    cfg_we = 1'b1;
    reset_model(size_cfg);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Sender, sampling side: a request is taken when valid and ready are both high at the
  // rising edge, and its result is predicted at that moment.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(table_access(in_req));
      in_taken = 1'b1;
    end
  end

  // Sender, driving side: after each accepted request it idles for a drawn number of
  // cycles, then offers the next pending request and holds it until it is taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        tx_live = 1'b0;
        tx_gap = draw_gap(tx_quiet);
      end
      if (!tx_live) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_reqs.size() != 0) begin
          in_req <= pending_reqs.pop_front();
          tx_live = 1'b1;
        end
      end
      in_valid <= tx_live;
    end
  end

  // Receiver, sampling side: every result taken is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      rx_taken = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: status %0d value %h",
               out_res.status, out_res.value);
        mismatches++;
      end else begin
        rx_want = expected_results.pop_front();
        if (out_res.status !== rx_want.status) begin
          $error("status: expected %0d, got %0d", rx_want.status, out_res.status);
          mismatches++;
        end
        if (out_res.value !== rx_want.value) begin
          $error("value: expected %h, got %h", rx_want.value, out_res.value);
          mismatches++;
        end
      end
    end
  end

  // Receiver, driving side: stalls for a drawn number of cycles after each result, and
  // once on request for a long stretch while the sender keeps offering.
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold = LONG_HOLD;
      end
      if (rx_taken) begin
        rx_taken = 1'b0;
        rx_wait = draw_gap(rx_quiet);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [CFG_W-1:0] size_cfg;
    logic [63:0] rnd;
    logic [KEY_W-1:0] key_base;
    logic [KEY_W-1:0] key;
    logic [ACT_W-1:0] act;
    int phase;
    int sent;
    int count;
    int pool;
    int pick;

    reset_model(CFG_RESET);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset size. Key 1024 shares the home slot of key 0, so these
    // requests build a probe chain: a duplicate insert, a tombstone at the head of the
    // chain, and searches that must walk past it.
    queue_req(ACT_INSERT, '0, '0);
    queue_req(ACT_INSERT, 63'd1024, DATA_TOP);
    queue_req(ACT_INSERT, '0, 64'h5555_5555_5555_5555);
    queue_req(ACT_SEARCH, '0, DATA_TOP);
    queue_req(ACT_SEARCH, 63'd1024, '0);
    queue_req(ACT_DELETE, '0, DATA_TOP);
    queue_req(ACT_SEARCH, '0, '0);
    queue_req(ACT_SEARCH, KEY_TOP, '0);
    queue_req(ACT_INSERT, KEY_TOP, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_req(ACT_SEARCH, KEY_TOP, '0);
    queue_req(ACT_UNUSED, KEY_TOP, DATA_TOP);
    queue_req(ACT_DELETE, 63'd5, '0);
    wait_drained();

    // A size of zero acts as a single slot: the second insert finds the table full, and
    // searches that go twice round the one slot must still answer "not found".
    write_table_size('0);
    queue_req(ACT_INSERT, 63'd7, 64'h0123_4567_89AB_CDEF);
    queue_req(ACT_INSERT, 63'd8, DATA_TOP);
    queue_req(ACT_SEARCH, 63'd8, '0);
    queue_req(ACT_SEARCH, 63'd7, '0);
    queue_req(ACT_DELETE, 63'd7, '0);
    queue_req(ACT_SEARCH, 63'd7, '0);
    queue_req(ACT_INSERT, 63'd8, 64'hFEDC_BA98_7654_3210);
    queue_req(ACT_DELETE, KEY_TOP, '0);
    wait_drained();

    // Random part in phases, each with its own size. Keys mostly come from a small pool
    // near a random base so that hits, collisions, tombstones and full tables are common;
    // the rest are drawn from the whole key range. Large sizes get only a few requests.
    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: size_cfg = 11'd2047;
        1: size_cfg = 11'd1;
        2: size_cfg = 11'd1024;
        3: size_cfg = 11'd2;
        4: size_cfg = 11'd1025;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            size_cfg = CFG_W'($urandom_range(1025, 2047));
          end else if (pick < 3) begin
            size_cfg = CFG_W'($urandom_range(100, 300));
          end else begin
            size_cfg = CFG_W'($urandom_range(1, 24));
          end
        end
      endcase
      write_table_size(size_cfg);
      count = (tbl_size > 300) ? 25 : $urandom_range(40, 110);
      pool = (2 * tbl_size + 3 > 80) ? 80 : 2 * tbl_size + 3;
      rnd = {$urandom, $urandom};
      key_base = rnd[KEY_W-1:0];
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          act = ACT_INSERT;
        end else if (pick < 75) begin
          act = ACT_SEARCH;
        end else if (pick < 96) begin
          act = ACT_DELETE;
        end else begin
          act = ACT_UNUSED;
        end
        if ($urandom_range(0, 6) == 0) begin
          rnd = {$urandom, $urandom};
          key = rnd[KEY_W-1:0];
        end else begin
          key = key_base + KEY_W'($urandom_range(0, pool - 1));
        end
        queue_req(act, key, {$urandom, $urandom});
      end
      sent += count;
      // In one early phase the receiver stops for a long while with requests still queued.
      if (phase == 1) begin
        rx_hold_req = 1'b1;
      end
      phase++;
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legitimate run.
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
